// ----- sv/wrms_pkg.sv -----
`timescale 1ns / 1ps
package wrms_pkg;

    localparam int MAX_WINDOW_DEF  = 4096;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int WLEN_BITS       = 13;
    localparam int THR_BITS        = 16;
    localparam int RMS_BITS        = 15;
    localparam int TSUM_BITS       = 64;
    localparam int TCNT_BITS       = 32;
    localparam int DIV_BITS        = 64;
    localparam int DEN_BITS        = 32;
    localparam int ROOT_BITS       = 32;
    localparam int CFG_ADDR_BITS   = 1;
    localparam int CFG_DATA_BITS   = 16;

    localparam logic [CFG_ADDR_BITS-1:0] REG_WINDOW_LENGTH   = 1'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_LEVEL_THRESHOLD = 1'd1;

    localparam logic ACT_PUSH  = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    localparam logic [WLEN_BITS-1:0] WLEN_RESET = 13'd1024;
    localparam logic [THR_BITS-1:0]  THR_RESET  = 16'd328;

    typedef enum logic [3:0] {
        t_IDLE,
        t_READ,
        t_UPDATE,
        t_DIV_W_START,
        t_DIV_W_WAIT,
        t_DIV_T_START,
        t_DIV_T_WAIT,
        t_SQRT_W_START,
        t_SQRT_W_WAIT,
        t_SQRT_T_START,
        t_SQRT_T_WAIT,
        t_OUT
    } t_state;

    typedef struct packed {
        logic start_div;
        logic start_sqrt;
    } t_ctl;

endpackage

// ----- sv/wrms_divider.sv -----
`timescale 1ns / 1ps
module wrms_divider (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [wrms_pkg::DIV_BITS-1:0] i_num,
    input  logic [wrms_pkg::DEN_BITS-1:0] i_den,
    output logic                          o_done,
    output logic [wrms_pkg::DIV_BITS-1:0] o_quot
);

    localparam int CNT_BITS = $clog2(wrms_pkg::DIV_BITS + 1);

    logic [wrms_pkg::DIV_BITS-1:0] r_quot, n_quot;
    logic [wrms_pkg::DEN_BITS:0]   r_rem, n_rem;
    logic [wrms_pkg::DEN_BITS-1:0] r_den, n_den;
    logic [CNT_BITS-1:0]           r_cnt, n_cnt;
    logic                          r_busy, n_busy;
    logic                          r_done, n_done;
    logic [wrms_pkg::DEN_BITS:0]   v_shift;

    always_comb begin
        n_quot = r_quot;
        n_rem  = r_rem;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        v_shift = {r_rem[wrms_pkg::DEN_BITS-1:0], r_quot[wrms_pkg::DIV_BITS-1]};
        if (i_start) begin
            n_quot = i_num;
            n_rem  = '0;
            n_den  = i_den;
            n_cnt  = CNT_BITS'(wrms_pkg::DIV_BITS);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (v_shift >= {1'b0, r_den}) begin
                n_rem  = v_shift - {1'b0, r_den};
                n_quot = {r_quot[wrms_pkg::DIV_BITS-2:0], 1'b1};
            end else begin
                n_rem  = v_shift;
                n_quot = {r_quot[wrms_pkg::DIV_BITS-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_BITS'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_den  <= n_den;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ----- sv/wrms_sqrt.sv -----
`timescale 1ns / 1ps
module wrms_sqrt (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [wrms_pkg::DIV_BITS-1:0]  i_val,
    output logic                           o_done,
    output logic [wrms_pkg::ROOT_BITS-1:0] o_root
);

    localparam int CNT_BITS = $clog2(wrms_pkg::ROOT_BITS + 1);

    logic [wrms_pkg::DIV_BITS-1:0]  r_val, n_val;
    logic [wrms_pkg::ROOT_BITS+1:0] r_rem, n_rem;
    logic [wrms_pkg::ROOT_BITS-1:0] r_root, n_root;
    logic [CNT_BITS-1:0]            r_cnt, n_cnt;
    logic                           r_busy, n_busy;
    logic                           r_done, n_done;
    logic [wrms_pkg::ROOT_BITS+1:0] v_rem;
    logic [wrms_pkg::ROOT_BITS+1:0] v_trial;

    always_comb begin
        n_val  = r_val;
        n_rem  = r_rem;
        n_root = r_root;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        v_rem   = {r_rem[wrms_pkg::ROOT_BITS-1:0], r_val[wrms_pkg::DIV_BITS-1 -: 2]};
        v_trial = {r_root, 2'b01};
        if (i_start) begin
            n_val  = i_val;
            n_rem  = '0;
            n_root = '0;
            n_cnt  = CNT_BITS'(wrms_pkg::ROOT_BITS);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_val = {r_val[wrms_pkg::DIV_BITS-3:0], 2'b00};
            if (v_rem >= v_trial) begin
                n_rem  = v_rem - v_trial;
                n_root = {r_root[wrms_pkg::ROOT_BITS-2:0], 1'b1};
            end else begin
                n_rem  = v_rem;
                n_root = {r_root[wrms_pkg::ROOT_BITS-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_BITS'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_val  <= n_val;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ----- sv/windowed_rms_level_meter_core.sv -----
`timescale 1ns / 1ps
// A sample result is offered after one ring read, one update, two passes of the shared
// 64-step divider and two passes of the shared 32-step root unit. One item is in flight
// at a time: no new item is accepted until the last result has transferred.
// A clear item goes from the ring read straight to the output. Synchronous active-low reset
// clears all sums, counts and positions and loads the register defaults; the ring itself
// is not cleared.
module windowed_rms_level_meter_core #(
    parameter int MAX_WINDOW  = wrms_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = wrms_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [wrms_pkg::CFG_ADDR_BITS-1:0]  i_cfg_addr,
    input  logic [wrms_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_action,
    input  logic signed [SAMPLE_BITS-1:0]       i_sample,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [wrms_pkg::RMS_BITS-1:0]       o_recent_rms,
    output logic [wrms_pkg::RMS_BITS-1:0]       o_total_rms,
    output logic                                o_significant,
    output logic                                o_empty_res
);

    localparam int AW     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int FW     = $clog2(MAX_WINDOW + 1);
    localparam int SQ_W   = 2 * (SAMPLE_BITS - 1);
    localparam int WSUM_W = SQ_W + FW;
    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_NEG = S_MIN + 1'b1;
    localparam logic [AW:0] MAXW = (AW+1)'(MAX_WINDOW);
    localparam logic [AW-1:0] WPOS_LAST = AW'(MAX_WINDOW - 1);

    wrms_pkg::t_state r_state, n_state;
    wrms_pkg::t_ctl   w_ctl;

    logic signed [SAMPLE_BITS-1:0] r_ring [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] r_old;
    logic [AW-1:0]   r_wpos;
    logic [FW-1:0]   r_fill;
    logic [WSUM_W-1:0] r_wsum;
    logic [wrms_pkg::TSUM_BITS-1:0] r_tsum;
    logic [wrms_pkg::TCNT_BITS-1:0] r_tcnt;
    logic [wrms_pkg::WLEN_BITS-1:0] r_wlen;
    logic [wrms_pkg::THR_BITS-1:0]  r_thr;
    logic signed [SAMPLE_BITS-1:0] r_s;
    logic r_clear;
    logic [wrms_pkg::DIV_BITS-1:0] r_wmean, r_tmean;
    logic [wrms_pkg::RMS_BITS-1:0] r_recent, r_total;
    logic r_sig, r_empty, r_ovalid;

    logic [FW-1:0] w_eff;
    logic [AW:0]   w_eff_ext;
    logic [AW-1:0] w_old_addr;
    logic [SAMPLE_BITS-1:0] w_mag, w_old_mag;
    logic [SQ_W-1:0] w_sq, w_old_sq;
    logic [wrms_pkg::TSUM_BITS:0] w_tsum_add;
    logic w_full;
    logic w_accept;

    logic [wrms_pkg::DIV_BITS-1:0]  w_div_num, w_quot;
    logic [wrms_pkg::DEN_BITS-1:0]  w_div_den;
    logic [wrms_pkg::DIV_BITS-1:0]  w_sq_in;
    logic [wrms_pkg::ROOT_BITS-1:0] w_root;
    logic w_div_done, w_sqrt_done;

    always_comb begin
        if (r_wlen == '0) begin
            w_eff = FW'(1);
        end else if ({{(32-wrms_pkg::WLEN_BITS){1'b0}}, r_wlen} > 32'(MAX_WINDOW)) begin
            w_eff = FW'(MAX_WINDOW);
        end else begin
            w_eff = FW'(r_wlen);
        end
    end

    assign w_eff_ext  = (AW+1)'(w_eff);
    assign w_old_addr = ({1'b0, r_wpos} >= w_eff_ext) ? AW'({1'b0, r_wpos} - w_eff_ext)
                                                      : AW'({1'b0, r_wpos} + MAXW - w_eff_ext);
    assign w_full     = (r_fill >= w_eff);
    assign w_mag      = r_s[SAMPLE_BITS-1] ? SAMPLE_BITS'(-r_s) : SAMPLE_BITS'(r_s);
    assign w_old_mag  = r_old[SAMPLE_BITS-1] ? SAMPLE_BITS'(-r_old) : SAMPLE_BITS'(r_old);
    assign w_sq       = SQ_W'(w_mag[SAMPLE_BITS-2:0] * w_mag[SAMPLE_BITS-2:0]);
    assign w_old_sq   = SQ_W'(w_old_mag[SAMPLE_BITS-2:0] * w_old_mag[SAMPLE_BITS-2:0]);
    assign w_tsum_add = {1'b0, r_tsum} + (wrms_pkg::TSUM_BITS+1)'(w_sq);
    assign w_accept   = i_valid && !o_stall;
    assign o_stall    = (r_state != wrms_pkg::t_IDLE) || r_ovalid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            wrms_pkg::t_IDLE:         if (w_accept) n_state = wrms_pkg::t_READ;
            wrms_pkg::t_READ:         n_state = r_clear ? wrms_pkg::t_OUT : wrms_pkg::t_UPDATE;
            wrms_pkg::t_UPDATE:       n_state = wrms_pkg::t_DIV_W_START;
            wrms_pkg::t_DIV_W_START:  n_state = wrms_pkg::t_DIV_W_WAIT;
            wrms_pkg::t_DIV_W_WAIT:   if (w_div_done) n_state = wrms_pkg::t_DIV_T_START;
            wrms_pkg::t_DIV_T_START:  n_state = wrms_pkg::t_DIV_T_WAIT;
            wrms_pkg::t_DIV_T_WAIT:   if (w_div_done) n_state = wrms_pkg::t_SQRT_W_START;
            wrms_pkg::t_SQRT_W_START: n_state = wrms_pkg::t_SQRT_W_WAIT;
            wrms_pkg::t_SQRT_W_WAIT:  if (w_sqrt_done) n_state = wrms_pkg::t_SQRT_T_START;
            wrms_pkg::t_SQRT_T_START: n_state = wrms_pkg::t_SQRT_T_WAIT;
            wrms_pkg::t_SQRT_T_WAIT:  if (w_sqrt_done) n_state = wrms_pkg::t_OUT;
            wrms_pkg::t_OUT:          n_state = wrms_pkg::t_IDLE;
            default:                  n_state = wrms_pkg::t_IDLE;
        endcase
    end

    always_comb begin
        w_ctl     = '0;
        w_div_num = {{(wrms_pkg::DIV_BITS-WSUM_W){1'b0}}, r_wsum};
        w_div_den = wrms_pkg::DEN_BITS'(r_fill);
        w_sq_in   = r_wmean;
        case (r_state)
            wrms_pkg::t_DIV_W_START: w_ctl.start_div = 1'b1;
            wrms_pkg::t_DIV_T_START: begin
                w_ctl.start_div = 1'b1;
                w_div_num = r_tsum;
                w_div_den = r_tcnt;
            end
            wrms_pkg::t_SQRT_W_START: w_ctl.start_sqrt = 1'b1;
            wrms_pkg::t_SQRT_T_START: begin
                w_ctl.start_sqrt = 1'b1;
                w_sq_in = r_tmean;
            end
            default: w_ctl = '0;
        endcase
    end

    wrms_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_ctl.start_div),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    wrms_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_ctl.start_sqrt),
        .i_val   (w_sq_in),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (r_state == wrms_pkg::t_READ) begin
            r_old <= r_ring[w_old_addr];
        end
        if (r_state == wrms_pkg::t_UPDATE) begin
            r_ring[r_wpos] <= r_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= wrms_pkg::t_IDLE;
            r_wpos   <= '0;
            r_fill   <= '0;
            r_wsum   <= '0;
            r_tsum   <= '0;
            r_tcnt   <= '0;
            r_wlen   <= wrms_pkg::WLEN_RESET;
            r_thr    <= wrms_pkg::THR_RESET;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    wrms_pkg::REG_WINDOW_LENGTH: begin
                        r_wlen <= i_cfg_data[wrms_pkg::WLEN_BITS-1:0];
                        r_fill <= '0;
                        r_wsum <= '0;
                    end
                    wrms_pkg::REG_LEVEL_THRESHOLD: r_thr <= i_cfg_data;
                    default: r_thr <= r_thr;
                endcase
            end
            if (r_state == wrms_pkg::t_READ && r_clear) begin
                r_wpos <= '0;
                r_fill <= '0;
                r_wsum <= '0;
                r_tsum <= '0;
                r_tcnt <= '0;
            end
            if (r_state == wrms_pkg::t_UPDATE) begin
                if (w_full) begin
                    r_wsum <= r_wsum - WSUM_W'(w_old_sq) + WSUM_W'(w_sq);
                    r_fill <= w_eff;
                end else begin
                    r_wsum <= r_wsum + WSUM_W'(w_sq);
                    r_fill <= r_fill + 1'b1;
                end
                r_wpos <= (r_wpos == WPOS_LAST) ? '0 : r_wpos + 1'b1;
                if (r_tcnt != '1) begin
                    r_tcnt <= r_tcnt + 1'b1;
                    r_tsum <= w_tsum_add[wrms_pkg::TSUM_BITS] ? '1
                                  : w_tsum_add[wrms_pkg::TSUM_BITS-1:0];
                end
            end
            if (r_state == wrms_pkg::t_OUT) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
        if (w_accept) begin
            r_clear <= (i_action == wrms_pkg::ACT_CLEAR);
            r_s     <= (i_sample == S_MIN) ? S_NEG : i_sample;
        end
        if (r_state == wrms_pkg::t_DIV_W_WAIT && w_div_done) r_wmean <= w_quot;
        if (r_state == wrms_pkg::t_DIV_T_WAIT && w_div_done) r_tmean <= w_quot;
        if (r_state == wrms_pkg::t_SQRT_W_WAIT && w_sqrt_done) begin
            r_recent <= w_root[wrms_pkg::RMS_BITS-1:0];
        end
        if (r_state == wrms_pkg::t_SQRT_T_WAIT && w_sqrt_done) begin
            r_total <= w_root[wrms_pkg::RMS_BITS-1:0];
        end
        if (r_state == wrms_pkg::t_OUT) begin
            if (r_clear || r_tcnt == '0) begin
                r_recent <= '0;
                r_total  <= '0;
                r_sig    <= 1'b0;
                r_empty  <= 1'b1;
            end else begin
                r_sig   <= ({1'b0, r_total} >= r_thr);
                r_empty <= 1'b0;
            end
        end
    end

    assign o_valid       = r_ovalid;
    assign o_recent_rms  = r_recent;
    assign o_total_rms   = r_total;
    assign o_significant = r_sig;
    assign o_empty_res   = r_empty;

endmodule
